// ----- src/sdaf_pkg.sv -----
`default_nettype none

package sdaf_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int CHAR_WIDTH = 7;
  localparam int CFG_WIDTH = 4;
  localparam int MAX_DIGITS_DEFAULT = 10;

  // Double-dabble conversion is spread over this many register stages.
  localparam int DABBLE_STAGES = 4;
  localparam int STEPS_PER_STAGE = VALUE_WIDTH / DABBLE_STAGES;

  localparam logic [CFG_WIDTH-1:0] DIGIT_COUNT_RESET = 4'd10;
  localparam logic [CFG_WIDTH-1:0] POINT_POSITION_RESET = 4'd0;

  // Register select is paddr[2]: one 32-bit register per word.
  localparam logic REG_DIGIT_COUNT = 1'b0;
  localparam logic REG_POINT_POSITION = 1'b1;

  localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 7'h20;
  localparam logic [CHAR_WIDTH-1:0] CH_POINT = 7'h2E;
  localparam logic [CHAR_WIDTH-1:0] CH_ZERO = 7'h30;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] digit_count;
    logic [CFG_WIDTH-1:0] point_position;
  } sdaf_cfg_t;

endpackage

`default_nettype wire

// ----- src/sdaf_dabble_stage.sv -----
`default_nettype none

module sdaf_dabble_stage
  import sdaf_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    in_neg,
  input  wire logic [VALUE_WIDTH-1:0]  in_bin,
  input  wire logic [4*MAX_DIGITS-1:0] in_bcd,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         out_neg,
  output logic [VALUE_WIDTH-1:0]       out_bin,
  output logic [4*MAX_DIGITS-1:0]      out_bcd
);

  localparam int BW = 4 * MAX_DIGITS;

  logic [BW-1:0]          bcd_next;
  logic [VALUE_WIDTH-1:0] bin_next;

  assign in_ready = !out_valid || out_ready;

  // Digits above the kept ones are simply shifted out: corrections only
  // carry upward, so the low digits stay exact.
  always_comb begin
    bcd_next = in_bcd;
    bin_next = in_bin;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
        if (bcd_next[4*d +: 4] >= 4'd5) begin
          bcd_next[4*d +: 4] = bcd_next[4*d +: 4] + 4'd3;
        end
      end
      bcd_next = {bcd_next[BW-2:0], bin_next[VALUE_WIDTH-1]};
      bin_next = {bin_next[VALUE_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_neg <= in_neg;
      out_bin <= bin_next;
      out_bcd <= bcd_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/sdaf_emitter.sv -----
`default_nettype none

module sdaf_emitter
  import sdaf_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire sdaf_cfg_t               cfg,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    in_neg,
  input  wire logic [4*MAX_DIGITS-1:0] in_bcd,
  output logic                         strobe,
  output logic [CHAR_WIDTH-1:0]        ascii_char,
  output logic                         last_char
);

  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int IDXW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [CFG_WIDTH-1:0] MAX_CFG = CFG_WIDTH'(MAX_DIGITS);

  typedef enum logic [1:0] {
    IDLE,
    SIGN,
    POINT,
    DIGIT
  } emit_state_t;

  emit_state_t             state;
  logic                    neg;
  logic [4*MAX_DIGITS-1:0] bcd;
  logic [CW-1:0]           idx;

  logic [CW-1:0]   count_sat;
  logic [CW-1:0]   idx_dec;
  logic [IDXW-1:0] digit_sel;
  logic [3:0]      digit;
  logic            done;

  assign count_sat = (cfg.digit_count > MAX_CFG) ? CW'(MAX_DIGITS)
                                                 : cfg.digit_count[CW-1:0];
  assign idx_dec   = idx - CW'(1);
  assign digit_sel = idx_dec[IDXW-1:0];
  assign digit     = bcd[4*digit_sel +: 4];

  always_comb begin
    ascii_char = CH_SPACE;
    last_char  = 1'b0;
    unique case (state)
      IDLE: begin
        ascii_char = CH_SPACE;
        last_char  = 1'b0;
      end
      SIGN: begin
        ascii_char = neg ? CH_MINUS : CH_SPACE;
        last_char  = (idx == '0);
      end
      POINT: begin
        ascii_char = CH_POINT;
        last_char  = 1'b0;
      end
      DIGIT: begin
        ascii_char = CH_ZERO + {3'b000, digit};
        last_char  = (idx == CW'(1));
      end
      default: begin
        ascii_char = CH_SPACE;
        last_char  = 1'b0;
      end
    endcase
  end

  assign strobe   = (state != IDLE);
  assign done     = strobe && last_char;
  // A new value loads in the cycle the previous run ends, with no gap.
  assign in_ready = (state == IDLE) || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else if (in_ready) begin
      if (in_valid) begin
        state <= SIGN;
        neg   <= in_neg;
        bcd   <= in_bcd;
        idx   <= count_sat;
      end else begin
        state <= IDLE;
      end
    end else begin
      unique case (state)
        SIGN: begin
          state <= (CFG_WIDTH'(idx) == cfg.point_position) ? POINT : DIGIT;
        end
        POINT: begin
          state <= DIGIT;
        end
        DIGIT: begin
          idx   <= idx_dec;
          state <= (CFG_WIDTH'(idx_dec) == cfg.point_position) ? POINT : DIGIT;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_point_then_digit: assert property (@(posedge clk) disable iff (rst)
    state == POINT |=> state == DIGIT)
    else $error("decimal point not followed by a digit");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_char |=> strobe)
    else $error("character run broken before its last beat");

  a_load_sign: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == SIGN)
    else $error("accepted value did not start with its sign beat");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> idx <= CW'(MAX_DIGITS))
    else $error("digit index beyond the kept digits");

endmodule

`default_nettype wire

// ----- src/signed_decimal_ascii_formatter.sv -----
`default_nettype none
// A value accepted by start passes one input stage and four conversion stages before its first
// character (the sign beat) appears, once the character output is free. Each value then occupies
// the output for its sign beat, its digits and, with a decimal point, one point beat;
// that character serializer sets the sustained rate, and busy rises once the stages are full.
// The result beats cannot be stalled. Synchronous reset empties all stages and sets
// digit_count to 10 and point_position to 0.

module signed_decimal_ascii_formatter
  import sdaf_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [VALUE_WIDTH-1:0] value,
  output logic                              strobe,
  output logic [CHAR_WIDTH-1:0]             ascii_char,
  output logic                              last_char,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int BW = 4 * MAX_DIGITS;

  sdaf_cfg_t cfg;
  logic      cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.digit_count    <= DIGIT_COUNT_RESET;
      cfg.point_position <= POINT_POSITION_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_DIGIT_COUNT:    cfg.digit_count    <= pwdata[CFG_WIDTH-1:0];
        REG_POINT_POSITION: cfg.point_position <= pwdata[CFG_WIDTH-1:0];
        default:            cfg.digit_count    <= cfg.digit_count;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DIGIT_COUNT:    prdata = {28'd0, cfg.digit_count};
      REG_POINT_POSITION: prdata = {28'd0, cfg.point_position};
      default:            prdata = '0;
    endcase
  end

  // Pipeline links: index 0 is the input stage, DABBLE_STAGES feeds the serializer.
  logic                   lk_valid [0:DABBLE_STAGES];
  logic                   lk_ready [0:DABBLE_STAGES];
  logic                   lk_neg   [0:DABBLE_STAGES];
  logic [VALUE_WIDTH-1:0] lk_bin   [0:DABBLE_STAGES];
  logic [BW-1:0]          lk_bcd   [0:DABBLE_STAGES];

  logic                   s0_valid;
  logic                   s0_neg;
  logic [VALUE_WIDTH-1:0] s0_mag;
  logic                   s0_ready;
  logic                   accept;

  assign s0_ready = !s0_valid || lk_ready[0];
  assign busy     = !s0_ready;
  assign accept   = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_ready) begin
      s0_valid <= accept;
    end
  end

  // The magnitude is taken as unsigned, so the most negative value needs no extra bit.
  always_ff @(posedge clk) begin
    if (accept) begin
      s0_neg <= value[VALUE_WIDTH-1];
      s0_mag <= value[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - VALUE_WIDTH'(value))
                                     : VALUE_WIDTH'(value);
    end
  end

  assign lk_valid[0] = s0_valid;
  assign lk_neg[0]   = s0_neg;
  assign lk_bin[0]   = s0_mag;
  assign lk_bcd[0]   = '0;

  for (genvar k = 0; k < DABBLE_STAGES; k++) begin : g_dabble
    sdaf_dabble_stage #(
      .MAX_DIGITS(MAX_DIGITS)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_valid (lk_valid[k]),
      .in_ready (lk_ready[k]),
      .in_neg   (lk_neg[k]),
      .in_bin   (lk_bin[k]),
      .in_bcd   (lk_bcd[k]),
      .out_valid(lk_valid[k+1]),
      .out_ready(lk_ready[k+1]),
      .out_neg  (lk_neg[k+1]),
      .out_bin  (lk_bin[k+1]),
      .out_bcd  (lk_bcd[k+1])
    );
  end

  sdaf_emitter #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_emitter (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (lk_valid[DABBLE_STAGES]),
    .in_ready  (lk_ready[DABBLE_STAGES]),
    .in_neg    (lk_neg[DABBLE_STAGES]),
    .in_bcd    (lk_bcd[DABBLE_STAGES]),
    .strobe    (strobe),
    .ascii_char(ascii_char),
    .last_char (last_char)
  );

endmodule

`default_nettype wire
